>>> design/pcw_pkg.sv
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared types, register indexes and the microcode table of the periodic
// cell wrap block.
// ----------------------------------------------------------------------------
package pcw_pkg;

  // configuration register geometry
  localparam int REG_W     = 63;
  localparam int REG_COUNT = 7;
  localparam int IDX_W     = 3;

  // width of the per-axis shift count fields
  localparam int SHIFT_W = 11;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_LATTICE_0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_LATTICE_1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_LATTICE_2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORMAL_0  = 3'd3;
  localparam logic [IDX_W-1:0] REG_NORMAL_1  = 3'd4;
  localparam logic [IDX_W-1:0] REG_NORMAL_2  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ORIGIN    = 3'd6;

  // microcode operations
  typedef enum logic [2:0] {
    OP_WAIT,   // idle, waiting for a request
    OP_NA,     // accumulate normal dot lattice vector
    OP_DOT,    // accumulate normal dot (pos - origin)
    OP_TEST,   // face tests, shift and branch
    OP_DONE    // present the result
  } op_e;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t STEP_WAIT = 4'd0;
  localparam step_t STEP_NA   = 4'd1;
  localparam step_t STEP_DOT  = 4'd4;
  localparam step_t STEP_TEST = 4'd7;
  localparam step_t STEP_DONE = 4'd8;

  // one control word: operation, vector lane, accumulator clear and targets
  typedef struct packed {
    op_e        op;
    logic [1:0] lane;
    logic       clr;
    step_t      nxt;   // fall-through target
    step_t      jmp;   // taken when a shift was applied
    step_t      alt;   // taken when the item is finished
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{op: OP_WAIT, lane: 2'd0, clr: 1'b0,
          nxt: STEP_NA, jmp: STEP_WAIT, alt: STEP_WAIT};
    case (s)
      4'd0: w = '{OP_WAIT, 2'd0, 1'b0, STEP_NA,     STEP_WAIT, STEP_WAIT};
      4'd1: w = '{OP_NA,   2'd0, 1'b1, 4'd2,        STEP_WAIT, STEP_WAIT};
      4'd2: w = '{OP_NA,   2'd1, 1'b0, 4'd3,        STEP_WAIT, STEP_WAIT};
      4'd3: w = '{OP_NA,   2'd2, 1'b0, STEP_DOT,    STEP_WAIT, STEP_WAIT};
      4'd4: w = '{OP_DOT,  2'd0, 1'b1, 4'd5,        STEP_WAIT, STEP_WAIT};
      4'd5: w = '{OP_DOT,  2'd1, 1'b0, 4'd6,        STEP_WAIT, STEP_WAIT};
      4'd6: w = '{OP_DOT,  2'd2, 1'b0, STEP_TEST,   STEP_WAIT, STEP_WAIT};
      4'd7: w = '{OP_TEST, 2'd0, 1'b0, STEP_NA,     STEP_DOT,  STEP_DONE};
      4'd8: w = '{OP_DONE, 2'd0, 1'b0, STEP_WAIT,   STEP_WAIT, STEP_WAIT};
      default: w = '{OP_WAIT, 2'd0, 1'b0, STEP_WAIT, STEP_WAIT, STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/pcw_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcw_cfg_regs
// Configuration register file: lattice vectors, face normals and cell origin,
// unpacked into signed coordinate components.
// ----------------------------------------------------------------------------
module pcw_cfg_regs #(
  parameter int COORD_BITS = 21
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    we_i,
  input  logic [pcw_pkg::IDX_W-1:0]               index_i,
  input  logic [pcw_pkg::REG_W-1:0]               data_i,
  output logic [2:0][2:0][COORD_BITS-1:0]         lat_o,
  output logic [2:0][2:0][COORD_BITS-1:0]         nrm_o,
  output logic [2:0][COORD_BITS-1:0]              org_o
);

  localparam int EXT_W = 3 * COORD_BITS + pcw_pkg::REG_W;

  logic [pcw_pkg::REG_W-1:0] lat_q [3];
  logic [pcw_pkg::REG_W-1:0] nrm_q [3];
  logic [pcw_pkg::REG_W-1:0] org_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q[0] <= '0;
      lat_q[1] <= '0;
      lat_q[2] <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= '0;
      org_q    <= '0;
    end else if (we_i) begin
      case (index_i)
        pcw_pkg::REG_LATTICE_0: lat_q[0] <= data_i;
        pcw_pkg::REG_LATTICE_1: lat_q[1] <= data_i;
        pcw_pkg::REG_LATTICE_2: lat_q[2] <= data_i;
        pcw_pkg::REG_NORMAL_0:  nrm_q[0] <= data_i;
        pcw_pkg::REG_NORMAL_1:  nrm_q[1] <= data_i;
        pcw_pkg::REG_NORMAL_2:  nrm_q[2] <= data_i;
        pcw_pkg::REG_ORIGIN:    org_q    <= data_i;
        default: ;
      endcase
    end
  end

  // unpack components, bits above the register read as zero
  always_comb begin
    logic [EXT_W-1:0] ext_org;
    logic [EXT_W-1:0] ext_lat;
    logic [EXT_W-1:0] ext_nrm;
    ext_org = {{(3 * COORD_BITS){1'b0}}, org_q};
    for (int k = 0; k < 3; k++) begin
      org_o[k] = ext_org[k * COORD_BITS +: COORD_BITS];
    end
    for (int i = 0; i < 3; i++) begin
      ext_lat = {{(3 * COORD_BITS){1'b0}}, lat_q[i]};
      ext_nrm = {{(3 * COORD_BITS){1'b0}}, nrm_q[i]};
      for (int k = 0; k < 3; k++) begin
        lat_o[i][k] = ext_lat[k * COORD_BITS +: COORD_BITS];
        nrm_o[i][k] = ext_nrm[k * COORD_BITS +: COORD_BITS];
      end
    end
  end

endmodule

>>> design/periodic_cell_wrap.sv
// ----------------------------------------------------------------------------
// periodic_cell_wrap
// Folds one 3-D fixed-point position into a parallelepiped cell, axis by
// axis, counting the lattice shifts applied along each axis.
// ----------------------------------------------------------------------------
// Usage
//   Configuration: write lattice vectors, face normals and the origin through
//   cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i. Ready is high
//   while the block is idle. All configuration registers reset to zero.
//   Request: drive pos_x_i, pos_y_i, pos_z_i with start_i while busy_o is
//   low; the request is taken at that clock edge and busy_o rises.
//   Result: all result ports are valid for exactly one cycle while done_o is
//   high; busy_o drops in the following cycle. The receiver cannot stall.
//   Sequence: from the request edge to the done cycle, each axis first forms
//   normal dot lattice vector, then runs face tests (3 products and a test
//   step each), repeated after every shift; the shift limit can end work
//   early. A single multiply-accumulate unit forms one product per cycle
//   under a small microcode program.
//   One request at a time; the next may start the cycle after done_o.
//   Reset: asynchronous, active low; the sequencer returns to idle.
// ----------------------------------------------------------------------------
module periodic_cell_wrap #(
  parameter int COORD_BITS = 21,
  parameter int MAX_SHIFTS = 1000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcw_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [pcw_pkg::REG_W-1:0]           cfg_data_i,
  // request
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  logic signed [COORD_BITS-1:0]        pos_z_i,
  // result
  output logic                                done_o,
  output logic signed [COORD_BITS-1:0]        wrapped_x_o,
  output logic signed [COORD_BITS-1:0]        wrapped_y_o,
  output logic signed [COORD_BITS-1:0]        wrapped_z_o,
  output logic signed [pcw_pkg::SHIFT_W-1:0]  axis0_shift_o,
  output logic signed [pcw_pkg::SHIFT_W-1:0]  axis1_shift_o,
  output logic signed [pcw_pkg::SHIFT_W-1:0]  axis2_shift_o,
  output logic                                moved_o,
  output logic                                too_many_shifts_o
);

  localparam int CB     = COORD_BITS;
  localparam int PROD_W = 2 * CB + 1;
  localparam int ACC_W  = 2 * CB + 4;
  localparam int TOT_W  = $clog2(MAX_SHIFTS + 2);
  localparam int CNT_W  = (TOT_W + 1 > pcw_pkg::SHIFT_W + 1) ? TOT_W + 1
                                                             : pcw_pkg::SHIFT_W + 1;
  localparam logic [TOT_W-1:0] TOT_LIMIT = TOT_W'(MAX_SHIFTS);
  localparam logic signed [CNT_W-1:0] CNT_HI = CNT_W'(2 ** (pcw_pkg::SHIFT_W - 1) - 1);
  localparam logic signed [CNT_W-1:0] CNT_LO = -CNT_HI - CNT_W'(1);

  // configuration
  logic [2:0][2:0][CB-1:0] lat;
  logic [2:0][2:0][CB-1:0] nrm;
  logic [2:0][CB-1:0]      org;
  logic                    cfg_we;

  assign cfg_ready_o = !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  pcw_cfg_regs #(
    .COORD_BITS(CB)
  ) u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .lat_o   (lat),
    .nrm_o   (nrm),
    .org_o   (org)
  );

  // sequencer and datapath registers
  pcw_pkg::step_t            step_q, step_d;
  pcw_pkg::ctrl_t            ctrl;
  logic [1:0]                axis_q, axis_d;
  logic [2:0][CB-1:0]        pos_q, pos_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   na_q, na_d;
  logic signed [CNT_W-1:0]   cnt_q [3];
  logic signed [CNT_W-1:0]   cnt_d [3];
  logic [TOT_W-1:0]          total_q, total_d;
  logic                      moved_q, moved_d;
  logic                      err_q, err_d;
  logic                      accept;

  assign ctrl   = pcw_pkg::ucode(step_q);
  assign busy_o = (ctrl.op != pcw_pkg::OP_WAIT);
  assign done_o = (ctrl.op == pcw_pkg::OP_DONE);
  assign accept = start_i && !busy_o;

  // saturating add or subtract of one lattice component
  function automatic logic [CB-1:0] sat_step(logic [CB-1:0] p, logic [CB-1:0] a,
                                             logic sub);
    logic [CB:0] sum;
    if (sub) begin
      sum = {p[CB-1], p} - {a[CB-1], a};
    end else begin
      sum = {p[CB-1], p} + {a[CB-1], a};
    end
    if (sum[CB] != sum[CB-1]) begin
      return sum[CB] ? {1'b1, {(CB - 1){1'b0}}} : {1'b0, {(CB - 1){1'b1}}};
    end
    return sum[CB-1:0];
  endfunction

  // shared multiply-accumulate operands
  logic signed [CB-1:0]     mul_a;
  logic signed [CB:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  mac_sum;
  logic signed [ACC_W-1:0]  far;
  logic                     go_add;
  logic                     go_sub;

  always_comb begin
    logic [CB-1:0] p_l;
    logic [CB-1:0] o_l;
    logic [CB-1:0] a_l;
    p_l   = pos_q[ctrl.lane];
    o_l   = org[ctrl.lane];
    a_l   = lat[axis_q][ctrl.lane];
    mul_a = $signed(nrm[axis_q][ctrl.lane]);
    if (ctrl.op == pcw_pkg::OP_NA) begin
      mul_b = $signed({a_l[CB-1], a_l});
    end else begin
      mul_b = $signed({p_l[CB-1], p_l}) - $signed({o_l[CB-1], o_l});
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    logic signed [ACC_W-1:0] base;
    if (ctrl.clr) begin
      base = '0;
    end else if (ctrl.op == pcw_pkg::OP_NA) begin
      base = na_q;
    end else begin
      base = acc_q;
    end
    mac_sum = base + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  end

  // face tests: behind the origin face, or past the far face
  assign far    = acc_q - na_q;
  assign go_add = acc_q < 0;
  assign go_sub = !go_add && (far > 0);

  // next step
  always_comb begin
    step_d = step_q;
    case (ctrl.op)
      pcw_pkg::OP_WAIT: begin
        if (start_i) step_d = ctrl.nxt;
      end
      pcw_pkg::OP_NA, pcw_pkg::OP_DOT, pcw_pkg::OP_DONE: begin
        step_d = ctrl.nxt;
      end
      pcw_pkg::OP_TEST: begin
        if (go_add || go_sub) begin
          step_d = (total_q == TOT_LIMIT) ? ctrl.alt : ctrl.jmp;
        end else begin
          step_d = (axis_q == 2'd2) ? ctrl.alt : ctrl.nxt;
        end
      end
      default: step_d = pcw_pkg::STEP_WAIT;
    endcase
  end

  // datapath updates
  always_comb begin
    axis_d  = axis_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    na_d    = na_q;
    total_d = total_q;
    moved_d = moved_q;
    err_d   = err_q;
    for (int k = 0; k < 3; k++) cnt_d[k] = cnt_q[k];
    case (ctrl.op)
      pcw_pkg::OP_WAIT: begin
        if (accept) begin
          axis_d  = 2'd0;
          pos_d   = {pos_z_i, pos_y_i, pos_x_i};
          total_d = '0;
          moved_d = 1'b0;
          err_d   = 1'b0;
          for (int k = 0; k < 3; k++) cnt_d[k] = '0;
        end
      end
      pcw_pkg::OP_NA:  na_d  = mac_sum;
      pcw_pkg::OP_DOT: acc_d = mac_sum;
      pcw_pkg::OP_TEST: begin
        if (go_add || go_sub) begin
          for (int k = 0; k < 3; k++) begin
            pos_d[k] = sat_step(pos_q[k], lat[axis_q][k], go_sub);
          end
          cnt_d[axis_q] = go_sub ? cnt_q[axis_q] - CNT_W'(1)
                                 : cnt_q[axis_q] + CNT_W'(1);
          total_d = total_q + TOT_W'(1);
          moved_d = 1'b1;
          if (total_q == TOT_LIMIT) err_d = 1'b1;
        end else if (axis_q != 2'd2) begin
          axis_d = axis_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= pcw_pkg::STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    axis_q  <= axis_d;
    pos_q   <= pos_d;
    acc_q   <= acc_d;
    na_q    <= na_d;
    total_q <= total_d;
    moved_q <= moved_d;
    err_q   <= err_d;
    for (int k = 0; k < 3; k++) cnt_q[k] <= cnt_d[k];
  end

  // result fields
  function automatic logic [pcw_pkg::SHIFT_W-1:0] clamp_cnt(logic signed [CNT_W-1:0] c);
    if (c > CNT_HI) return CNT_HI[pcw_pkg::SHIFT_W-1:0];
    if (c < CNT_LO) return CNT_LO[pcw_pkg::SHIFT_W-1:0];
    return c[pcw_pkg::SHIFT_W-1:0];
  endfunction

  assign wrapped_x_o       = err_q ? '0 : $signed(pos_q[0]);
  assign wrapped_y_o       = err_q ? '0 : $signed(pos_q[1]);
  assign wrapped_z_o       = err_q ? '0 : $signed(pos_q[2]);
  assign axis0_shift_o     = $signed(clamp_cnt(cnt_q[0]));
  assign axis1_shift_o     = $signed(clamp_cnt(cnt_q[1]));
  assign axis2_shift_o     = $signed(clamp_cnt(cnt_q[2]));
  assign moved_o           = moved_q;
  assign too_many_shifts_o = err_q;

  // checks
  a_busy_ends_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o))
    else $error("busy dropped without a result strobe");

  a_request_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_error_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && too_many_shifts_o) |-> (moved_o && wrapped_x_o == '0 &&
                                       wrapped_y_o == '0 && wrapped_z_o == '0))
    else $error("shift limit result carries a position");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic cell wrap block. A behavioral fold of
// each accepted position is computed from the bench's own copy of the cell
// registers and compared field by field with every done strobe. Directed
// cases cover faces, saturation and the shift limit; random triclinic cells
// with near-cell and full-range positions follow.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CB          = 21;
  localparam int     MAX_SHIFTS  = 1000;
  localparam longint COORD_MAX   = 2**(CB-1) - 1;
  localparam longint COORD_MIN   = -(2**(CB-1));
  localparam longint SHIFT_MAX   = 2**(pcw_pkg::SHIFT_W-1) - 1;
  localparam longint SHIFT_MIN   = -(2**(pcw_pkg::SHIFT_W-1));
  // watchdog limit, several times the worst request at the shift limit
  localparam int     STALL_LIMIT = 20000;

  typedef logic signed [CB-1:0]                coord_t;
  typedef logic signed [pcw_pkg::SHIFT_W-1:0]  shift_t;
  typedef logic [pcw_pkg::REG_W-1:0]           reg_t;

  typedef struct {
    coord_t x, y, z;
    shift_t s0, s1, s2;
    logic   moved;
    logic   err;
  } fold_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [pcw_pkg::IDX_W-1:0] cfg_index = '0;
  reg_t                      cfg_data  = '0;
  logic                      start     = 1'b0;
  logic                      busy;
  coord_t                    pos_x     = '0;
  coord_t                    pos_y     = '0;
  coord_t                    pos_z     = '0;
  logic                      done;
  coord_t                    wrapped_x, wrapped_y, wrapped_z;
  shift_t                    axis0_shift, axis1_shift, axis2_shift;
  logic                      moved, too_many_shifts;

  // bench copy of the cell registers
  reg_t  lat_reg [3] = '{default: '0};
  reg_t  nrm_reg [3] = '{default: '0};
  reg_t  org_reg     = '0;

  fold_t pending_folds [$];
  bit    failed       = 1'b0;
  int    stall_cycles = 0;

  periodic_cell_wrap #(
    .COORD_BITS(CB),
    .MAX_SHIFTS(MAX_SHIFTS)
  ) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .start_i          (start),
    .busy_o           (busy),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .pos_z_i          (pos_z),
    .done_o           (done),
    .wrapped_x_o      (wrapped_x),
    .wrapped_y_o      (wrapped_y),
    .wrapped_z_o      (wrapped_z),
    .axis0_shift_o    (axis0_shift),
    .axis1_shift_o    (axis1_shift),
    .axis2_shift_o    (axis2_shift),
    .moved_o          (moved),
    .too_many_shifts_o(too_many_shifts)
  );

  always #6 clk = ~clk;

  // packing helpers, x in the low bits
  function automatic reg_t pack3(longint x, longint y, longint z);
    return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
  endfunction

  function automatic longint coord_of(reg_t r, int k);
    return longint'(coord_t'(r[k*CB +: CB]));
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // fold one position into the cell held in the bench registers
  function automatic fold_t fold_position(longint px, longint py, longint pz);
    longint p [3];
    longint o [3];
    longint a [3][3];
    longint n [3][3];
    longint cnt [3];
    longint near_face, far_face, dir;
    int     total, i, j;
    bit     was_moved, err, settled;
    fold_t  f;
    p[0] = coord_of(pack3(px, py, pz), 0);
    p[1] = coord_of(pack3(px, py, pz), 1);
    p[2] = coord_of(pack3(px, py, pz), 2);
    total = 0;
    was_moved = 1'b0;
    err = 1'b0;
    for (j = 0; j < 3; j++) begin
      o[j] = coord_of(org_reg, j);
      cnt[j] = 0;
      for (i = 0; i < 3; i++) begin
        a[i][j] = coord_of(lat_reg[i], j);
        n[i][j] = coord_of(nrm_reg[i], j);
      end
    end
    // axes in order, each until the position sits between its two faces
    for (i = 0; i < 3 && !err; i++) begin
      settled = 1'b0;
      while (!settled && !err) begin
        near_face = 0;
        far_face = 0;
        for (j = 0; j < 3; j++) begin
          near_face += n[i][j] * (p[j] - o[j]);
          far_face  += n[i][j] * (p[j] - o[j] - a[i][j]);
        end
        if (near_face < 0) dir = 1;
        else if (far_face > 0) dir = -1;
        else dir = 0;
        if (dir == 0) begin
          settled = 1'b1;
        end else begin
          for (j = 0; j < 3; j++) p[j] = clamp_coord(p[j] + dir * a[i][j]);
          cnt[i] += dir;
          was_moved = 1'b1;
          total++;
          if (total > MAX_SHIFTS) err = 1'b1;
        end
      end
    end
    // shift counts saturate, out of reach with the default limit
    for (j = 0; j < 3; j++) begin
      if (cnt[j] > SHIFT_MAX) cnt[j] = SHIFT_MAX;
      if (cnt[j] < SHIFT_MIN) cnt[j] = SHIFT_MIN;
    end
    f.x = err ? '0 : coord_t'(p[0]);
    f.y = err ? '0 : coord_t'(p[1]);
    f.z = err ? '0 : coord_t'(p[2]);
    f.s0 = shift_t'(cnt[0]);
    f.s1 = shift_t'(cnt[1]);
    f.s2 = shift_t'(cnt[2]);
    f.moved = was_moved;
    f.err = err;
    return f;
  endfunction

  // one register write, valid left high for a following write
  task automatic write_reg(logic [pcw_pkg::IDX_W-1:0] idx, reg_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pcw_pkg::REG_LATTICE_0: lat_reg[0] = data;
      pcw_pkg::REG_LATTICE_1: lat_reg[1] = data;
      pcw_pkg::REG_LATTICE_2: lat_reg[2] = data;
      pcw_pkg::REG_NORMAL_0:  nrm_reg[0] = data;
      pcw_pkg::REG_NORMAL_1:  nrm_reg[1] = data;
      pcw_pkg::REG_NORMAL_2:  nrm_reg[2] = data;
      pcw_pkg::REG_ORIGIN:    org_reg    = data;
      default: ;
    endcase
  endtask

  task automatic load_cell(reg_t la0, reg_t la1, reg_t la2,
                           reg_t nr0, reg_t nr1, reg_t nr2, reg_t og);
    write_reg(pcw_pkg::REG_LATTICE_0, la0);
    write_reg(pcw_pkg::REG_LATTICE_1, la1);
    write_reg(pcw_pkg::REG_LATTICE_2, la2);
    write_reg(pcw_pkg::REG_NORMAL_0, nr0);
    write_reg(pcw_pkg::REG_NORMAL_1, nr1);
    write_reg(pcw_pkg::REG_NORMAL_2, nr2);
    write_reg(pcw_pkg::REG_ORIGIN, og);
    cfg_valid <= 1'b0;
  endtask

  // random lower-triangular cell with matching face normals
  task automatic load_triclinic(int unit);
    longint ax, bx, by, cx, cy, cz, sg, u;
    longint ox, oy, oz;
    ax = $urandom_range(1, 8);
    by = $urandom_range(1, 8);
    cz = $urandom_range(1, 8);
    bx = longint'($urandom_range(0, 8)) - 4;
    cx = longint'($urandom_range(0, 8)) - 4;
    cy = longint'($urandom_range(0, 8)) - 4;
    sg = ($urandom_range(0, 1) == 1) ? -1 : 1;
    u  = sg * unit;
    ox = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    oy = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    oz = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    load_cell(pack3(ax * u, 0, 0), pack3(bx * u, by * u, 0),
              pack3(cx * u, cy * u, cz * u),
              pack3(sg * by * cz, -sg * bx * cz, sg * (bx * cy - by * cx)),
              pack3(0, sg * cz * ax, -sg * cy * ax), pack3(0, 0, sg * ax * by),
              pack3(ox, oy, oz));
  endtask

  // one request, start left high so a following request needs no gap
  task automatic request_fold(longint x, longint y, longint z);
    pos_x <= coord_t'(x);
    pos_y <= coord_t'(y);
    pos_z <= coord_t'(z);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_folds.insert(pending_folds.size(), fold_position(x, y, z));
  endtask

  // position a few cells around the origin, some fields fully random
  task automatic request_near_cell(int span, int noise_pct);
    longint p [3];
    longint c [3];
    longint a, k, t;
    int     i, j;
    for (j = 0; j < 3; j++) p[j] = coord_of(org_reg, j);
    for (i = 0; i < 3; i++) begin
      k = longint'($urandom_range(0, 2 * span)) - span;
      t = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 4095);
      for (j = 0; j < 3; j++) begin
        a = coord_of(lat_reg[i], j);
        p[j] += k * a + ((t * a) >>> 12);
      end
    end
    for (j = 0; j < 3; j++)
      c[j] = ($urandom_range(0, 99) < noise_pct) ? longint'(coord_t'($urandom))
                                                 : clamp_coord(p[j]);
    request_fold(c[0], c[1], c[2]);
  endtask

  // random idle burst after a request, sometimes once the block is idle
  task automatic pace(bit allow);
    if (allow && $urandom_range(0, 2) != 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1)
        while (pending_folds.size() != 0) @(posedge clk);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // registers at reset: zero normals, nothing may move
  task automatic test_reset_cell();
    request_fold(COORD_MAX, COORD_MIN, 0);
    request_fold(COORD_MIN, COORD_MAX, -1);
    request_fold(0, 0, 0);
    request_fold(22'h0aaaaa, 22'h155555, 22'h0aaaaa);
    wait_idle();
  endtask

  // strict face tests, one add and one subtract per axis
  task automatic test_faces();
    load_cell(pack3(16384, 0, 0), pack3(0, 16384, 0), pack3(0, 0, 16384),
              pack3(1, 0, 0), pack3(0, 1, 0), pack3(0, 0, 1),
              pack3(-8192, -8192, -8192));
    request_fold(-8192, -8192, -8192);
    request_fold(8192, 8192, 8192);
    request_fold(-8193, 0, 0);
    request_fold(8193, 0, 0);
    request_fold(0, -8193, 0);
    request_fold(0, 8193, 0);
    request_fold(0, 0, -8193);
    request_fold(0, 0, 8193);
    request_fold(COORD_MAX, COORD_MIN, COORD_MAX);
    wait_idle();
  endtask

  // a skewed lattice vector drives y past both ends of the range
  task automatic test_saturation();
    load_cell(pack3(4096, 1000000, 0), '0, '0,
              pack3(1, 0, 0), '0, '0, '0);
    request_fold(-8192, 500000, 0);
    request_fold(8193, -500000, 0);
    wait_idle();
  endtask

  // zero lattice vector, tiny lattice vector, and the limit hit on axis one
  task automatic test_shift_limit();
    load_cell('0, '0, '0, pack3(1, 0, 0), '0, '0, '0);
    request_fold(-1, 0, 0);
    wait_idle();
    load_cell(pack3(1, 0, 0), '0, '0, pack3(1, 0, 0), '0, '0, '0);
    request_fold(COORD_MAX, 0, 0);
    wait_idle();
    load_cell(pack3(1024, 0, 0), pack3(0, 1024, 0), '0,
              pack3(1, 0, 0), pack3(0, 1, 0), '0, '0);
    request_fold(600000, 600000, 0);
    wait_idle();
  endtask

  // random cells, the first one as large as the range allows
  task automatic test_random_cells();
    int ph, n;
    for (ph = 0; ph < 6; ph++) begin
      load_triclinic((ph == 0) ? 131071 : $urandom_range(512, 32768));
      for (n = 0; n < 70; n++) begin
        if (ph == 0) request_near_cell(2, 60);
        else request_near_cell((n % 10 == 0) ? 6 : 1, 6);
        pace((n / 16) % 3 != 0);
      end
      wait_idle();
    end
  endtask

  // all-ones and full-scale registers, then random register contents
  task automatic test_extreme_registers();
    int n;
    load_cell('1, '1, '1, '1, '1, '1, '1);
    request_fold(0, 0, 0);
    request_fold(-1, -1, -1);
    wait_idle();
    load_cell(pack3(COORD_MAX, COORD_MAX, COORD_MAX),
              pack3(COORD_MAX, COORD_MAX, COORD_MAX),
              pack3(COORD_MAX, COORD_MAX, COORD_MAX),
              pack3(COORD_MAX, COORD_MAX, COORD_MAX),
              pack3(COORD_MAX, COORD_MAX, COORD_MAX),
              pack3(COORD_MAX, COORD_MAX, COORD_MAX),
              pack3(COORD_MIN, COORD_MIN, COORD_MIN));
    request_fold(COORD_MAX, COORD_MAX, COORD_MAX);
    request_fold(COORD_MIN, COORD_MIN, COORD_MIN);
    wait_idle();
    for (n = 0; n < 6; n++) begin
      load_cell(reg_t'({$urandom, $urandom}), reg_t'({$urandom, $urandom}),
                reg_t'({$urandom, $urandom}), reg_t'({$urandom, $urandom}),
                reg_t'({$urandom, $urandom}), reg_t'({$urandom, $urandom}),
                reg_t'({$urandom, $urandom}));
      request_near_cell(1, 0);
      wait_idle();
    end
  endtask

  // closing stretch with requests back to back
  task automatic test_back_to_back();
    int n;
    load_triclinic($urandom_range(2048, 16384));
    for (n = 0; n < 60; n++) request_near_cell(1, 0);
    wait_idle();
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // compare each result with the oldest outstanding request
  always @(posedge clk) begin
    fold_t want;
    if (rst_n && done) begin
      if (pending_folds.size() == 0) begin
        $error("result with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_folds.pop_front();
        check_field("wrapped_x", want.x, wrapped_x);
        check_field("wrapped_y", want.y, wrapped_y);
        check_field("wrapped_z", want.z, wrapped_z);
        check_field("axis0_shift", want.s0, axis0_shift);
        check_field("axis1_shift", want.s1, axis1_shift);
        check_field("axis2_shift", want.s2, axis2_shift);
        check_field("moved", want.moved, moved);
        check_field("too_many_shifts", want.err, too_many_shifts);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_cell();
    test_faces();
    test_saturation();
    test_shift_limit();
    test_random_cells();
    test_extreme_registers();
    test_back_to_back();
    // let any stray strobe show up
    repeat (40) @(posedge clk);
    if (!failed && pending_folds.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
design/pcw_pkg.sv
design/pcw_cfg_regs.sv
design/periodic_cell_wrap.sv
tb/sv/tb_top.sv
